/* src/ims_pkg.sv */
package ims_pkg;

    // Lattice geometry
    localparam int SIDE       = 64;
    localparam int ROW_W      = $clog2(SIDE);
    localparam int COL_W      = $clog2(SIDE);
    localparam int BANK_AW    = ROW_W - 1;
    localparam int BANK_DEPTH = SIDE / 2;

    // Field widths
    localparam int THR_W     = 17;
    localparam int RND_W     = 16;
    localparam int DE_W      = 6;
    localparam int EN_W      = 15;
    localparam int MAG_W     = 14;
    localparam int CFG_IDX_W = 2;

    typedef logic [ROW_W-1:0]       t_row;
    typedef logic [COL_W-1:0]       t_col;
    typedef logic [SIDE-1:0]        t_word;
    typedef logic [BANK_AW-1:0]     t_bank_addr;
    typedef logic [THR_W-1:0]       t_thr;
    typedef logic [RND_W-1:0]       t_rnd;
    typedef logic signed [DE_W-1:0] t_de;
    typedef logic signed [EN_W-1:0] t_energy;
    typedef logic signed [MAG_W-1:0] t_magnet;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THR_LOW  = 2'd0,
        CFG_THR_HIGH = 2'd1
    } t_cfg_idx;

    // Reset totals: all spins +1
    localparam t_energy EN_RESET  = t_energy'(-2 * SIDE * SIDE);
    localparam t_magnet MAG_RESET = t_magnet'(SIDE * SIDE);
    localparam t_magnet MAG_STEP  = t_magnet'(2);

    // Energy rise that selects the low threshold, and the offset in the energy change
    localparam t_de DE_FOUR  = t_de'(4);
    localparam t_de DE_EIGHT = t_de'(8);

    // Row write request into the lattice
    typedef struct packed {
        logic  en;
        t_row  row;
        t_word data;
    } t_wr_req;

    // The three rows around a site
    typedef struct packed {
        t_word up;
        t_word cur;
        t_word dn;
    } t_nbr;

endpackage

/* src/ising_metropolis_spin_update.sv */
// Results: a taken command passes the input register and then the result register,
// with o_result_valid high for a single cycle; results are not back-pressured.
// Throughput: one command per cycle; five spin reads come from two row banks
// (even and odd rows, two read ports each) and a same-row write is bypassed.
// Reset: totals return to the all +1 lattice, thresholds clear, and per-row valid
// flags make every row read as +1 at once; busy is high only while reset is held.
module ising_metropolis_spin_update (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_command,
    input  logic [ims_pkg::ROW_W-1:0]      i_row,
    input  logic [ims_pkg::COL_W-1:0]      i_column,
    input  logic                           i_spin_value,
    input  logic [ims_pkg::RND_W-1:0]      i_random_fraction,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ims_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ims_pkg::THR_W-1:0]      i_cfg_data,
    output logic                           o_result_valid,
    output logic                           o_accepted,
    output logic signed [ims_pkg::DE_W-1:0]  o_energy_change,
    output logic signed [ims_pkg::EN_W-1:0]  o_total_energy_out,
    output logic signed [ims_pkg::MAG_W-1:0] o_magnetization_out
);
    import ims_pkg::*;

    logic    accept;
    logic    cfg_xfer;
    t_nbr    nbr;
    t_wr_req wr;
    logic    flip;
    logic    old_spin;
    t_de     de;
    t_word   new_word;
    t_energy n_energy;
    t_magnet n_magnet;

    logic    r_stb;
    t_cmd    r_cmd;
    t_row    r_row;
    t_col    r_col;
    logic    r_want;
    t_rnd    r_rnd;
    t_thr    r_thr_low;
    t_thr    r_thr_high;
    t_energy r_energy;
    t_magnet r_magnet;
    logic    r_res_vld;
    logic    r_acc;
    t_de     r_de;
    t_energy r_en_out;
    t_magnet r_mag_out;

    assign busy        = ~i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign accept      = start && !busy;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;

    // Threshold registers; unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_low  <= '0;
            r_thr_high <= '0;
        end else if (cfg_xfer) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_THR_LOW:  r_thr_low  <= i_cfg_data;
                CFG_THR_HIGH: r_thr_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register stage (memory reads launch on the same edge)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stb <= 1'b0;
        end else begin
            r_stb <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= t_cmd'(i_command);
            r_row  <= i_row;
            r_col  <= i_column;
            r_want <= i_spin_value;
            r_rnd  <= i_random_fraction;
        end
    end

    ims_lattice u_lattice (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_row (i_row),
        .i_row_q  (r_row),
        .i_wr     (wr),
        .o_nbr    (nbr)
    );

    ims_flip_calc u_calc (
        .i_nbr      (nbr),
        .i_cmd      (r_cmd),
        .i_col      (r_col),
        .i_want     (r_want),
        .i_rnd      (r_rnd),
        .i_thr_low  (r_thr_low),
        .i_thr_high (r_thr_high),
        .o_flip     (flip),
        .o_old_spin (old_spin),
        .o_de       (de),
        .o_new_word (new_word)
    );

    // Write back the flipped row
    always_comb begin
        wr.en   = r_stb && flip;
        wr.row  = r_row;
        wr.data = new_word;
    end

    // Running totals after this command
    always_comb begin
        n_energy = r_energy;
        n_magnet = r_magnet;
        if (flip) begin
            n_energy = r_energy + t_energy'(de);
            n_magnet = old_spin ? (r_magnet - MAG_STEP) : (r_magnet + MAG_STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy  <= EN_RESET;
            r_magnet  <= MAG_RESET;
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= r_stb;
            if (r_stb) begin
                r_energy <= n_energy;
                r_magnet <= n_magnet;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (r_stb) begin
            r_acc     <= flip;
            r_de      <= flip ? de : '0;
            r_en_out  <= n_energy;
            r_mag_out <= n_magnet;
        end
    end

    assign o_result_valid      = r_res_vld;
    assign o_accepted          = r_acc;
    assign o_energy_change     = r_de;
    assign o_total_energy_out  = r_en_out;
    assign o_magnetization_out = r_mag_out;

endmodule

/* src/ims_row_bank.sv */
module ims_row_bank (
    input  logic                i_clk,
    input  logic                i_we,
    input  ims_pkg::t_bank_addr i_waddr,
    input  ims_pkg::t_word      i_wdata,
    input  ims_pkg::t_bank_addr i_raddr_a,
    input  ims_pkg::t_bank_addr i_raddr_b,
    output ims_pkg::t_word      o_rdata_a,
    output ims_pkg::t_word      o_rdata_b
);
    import ims_pkg::*;

    t_word r_mem [BANK_DEPTH];
    t_word r_rdata_a;
    t_word r_rdata_b;

    // One write port, two registered read ports; reads return old data on collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* src/ims_lattice.sv */
module ims_lattice (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ims_pkg::t_row    i_rd_row,
    input  ims_pkg::t_row    i_row_q,
    input  ims_pkg::t_wr_req i_wr,
    output ims_pkg::t_nbr    o_nbr
);
    import ims_pkg::*;

    t_row       rd_up;
    t_row       rd_dn;
    t_row       q_up;
    t_row       q_dn;
    t_bank_addr even_addr_a;
    t_bank_addr odd_addr_a;
    t_bank_addr addr_b;
    t_word      even_qa;
    t_word      even_qb;
    t_word      odd_qa;
    t_word      odd_qb;
    t_word      raw_up;
    t_word      raw_cur;
    t_word      raw_dn;

    logic [SIDE-1:0] r_row_vld;
    logic            r_vld_up;
    logic            r_vld_cur;
    logic            r_vld_dn;
    logic            r_fwd_en;
    t_row            r_fwd_row;
    t_word           r_fwd_data;

    // Periodic neighbor rows (wrap by the row width)
    assign rd_up = i_rd_row - t_row'(1);
    assign rd_dn = i_rd_row + t_row'(1);
    assign q_up  = i_row_q - t_row'(1);
    assign q_dn  = i_row_q + t_row'(1);

    // Up and down rows share the parity opposite to the current row
    assign even_addr_a = i_rd_row[0] ? rd_up[ROW_W-1:1] : i_rd_row[ROW_W-1:1];
    assign odd_addr_a  = i_rd_row[0] ? i_rd_row[ROW_W-1:1] : rd_up[ROW_W-1:1];
    assign addr_b      = rd_dn[ROW_W-1:1];

    ims_row_bank u_even (
        .i_clk     (i_clk),
        .i_we      (i_wr.en && !i_wr.row[0]),
        .i_waddr   (i_wr.row[ROW_W-1:1]),
        .i_wdata   (i_wr.data),
        .i_raddr_a (even_addr_a),
        .i_raddr_b (addr_b),
        .o_rdata_a (even_qa),
        .o_rdata_b (even_qb)
    );

    ims_row_bank u_odd (
        .i_clk     (i_clk),
        .i_we      (i_wr.en && i_wr.row[0]),
        .i_waddr   (i_wr.row[ROW_W-1:1]),
        .i_wdata   (i_wr.data),
        .i_raddr_a (odd_addr_a),
        .i_raddr_b (addr_b),
        .o_rdata_a (odd_qa),
        .o_rdata_b (odd_qb)
    );

    // Row valid flags: a row never written reads as all +1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_fwd_en  <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_row_vld[i_wr.row] <= 1'b1;
            end
            r_fwd_en <= i_wr.en;
        end
    end

    // Read-side flags and the last write, for bypass of same-edge collisions
    always_ff @(posedge i_clk) begin
        r_vld_up   <= r_row_vld[rd_up];
        r_vld_cur  <= r_row_vld[i_rd_row];
        r_vld_dn   <= r_row_vld[rd_dn];
        r_fwd_row  <= i_wr.row;
        r_fwd_data <= i_wr.data;
    end

    // Steer bank outputs back to up / current / down
    assign raw_cur = i_row_q[0] ? odd_qa  : even_qa;
    assign raw_up  = i_row_q[0] ? even_qa : odd_qa;
    assign raw_dn  = i_row_q[0] ? even_qb : odd_qb;

    function automatic t_word pick(input t_row row, input t_word raw, input logic vld,
                                   input logic fwd_en, input t_row fwd_row,
                                   input t_word fwd_data);
        t_word res;
        if (fwd_en && (fwd_row == row)) begin
            res = fwd_data;
        end else if (vld) begin
            res = raw;
        end else begin
            res = '1;
        end
        return res;
    endfunction

    always_comb begin
        o_nbr.up  = pick(q_up, raw_up, r_vld_up, r_fwd_en, r_fwd_row, r_fwd_data);
        o_nbr.cur = pick(i_row_q, raw_cur, r_vld_cur, r_fwd_en, r_fwd_row, r_fwd_data);
        o_nbr.dn  = pick(q_dn, raw_dn, r_vld_dn, r_fwd_en, r_fwd_row, r_fwd_data);
    end

endmodule

/* src/ims_flip_calc.sv */
module ims_flip_calc (
    input  ims_pkg::t_nbr  i_nbr,
    input  ims_pkg::t_cmd  i_cmd,
    input  ims_pkg::t_col  i_col,
    input  logic           i_want,
    input  ims_pkg::t_rnd  i_rnd,
    input  ims_pkg::t_thr  i_thr_low,
    input  ims_pkg::t_thr  i_thr_high,
    output logic           o_flip,
    output logic           o_old_spin,
    output ims_pkg::t_de   o_de,
    output ims_pkg::t_word o_new_word
);
    import ims_pkg::*;

    t_col       col_lf;
    t_col       col_rt;
    logic [2:0] n_up_cnt;
    t_de        de_pos;
    t_de        de;
    logic       step_ok;

    assign col_lf = i_col - t_col'(1);
    assign col_rt = i_col + t_col'(1);

    // Count of +1 neighbors k gives sum 2k-4, so dE = s*(4k-8)
    assign o_old_spin = i_nbr.cur[i_col];
    assign n_up_cnt   = 3'(i_nbr.up[i_col]) + 3'(i_nbr.dn[i_col])
                      + 3'(i_nbr.cur[col_lf]) + 3'(i_nbr.cur[col_rt]);
    assign de_pos     = t_de'({1'b0, n_up_cnt, 2'b00}) - DE_EIGHT;
    assign de         = o_old_spin ? de_pos : -de_pos;

    // Metropolis acceptance
    always_comb begin
        if (de[DE_W-1] || (de == '0)) begin
            step_ok = 1'b1;
        end else if (de == DE_FOUR) begin
            step_ok = ({1'b0, i_rnd} < i_thr_low);
        end else begin
            step_ok = ({1'b0, i_rnd} < i_thr_high);
        end
    end

    always_comb begin
        case (i_cmd)
            CMD_LOAD: o_flip = (i_want != o_old_spin);
            CMD_STEP: o_flip = step_ok;
            default:  o_flip = 1'b0;
        endcase
    end

    assign o_de       = de;
    assign o_new_word = i_nbr.cur ^ (t_word'(1) << i_col);

endmodule

/* src/ims_checker.sv */
module ims_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_result_valid,
    input logic                              o_accepted,
    input logic signed [ims_pkg::DE_W-1:0]   o_energy_change,
    input logic signed [ims_pkg::EN_W-1:0]   o_total_energy_out,
    input logic signed [ims_pkg::MAG_W-1:0]  o_magnetization_out
);
    import ims_pkg::*;

    // Every taken command yields its result through the input and result registers
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_result_valid)
        else $error("taken command produced no result");

    // No result without a matching taken command
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && $past(i_rst_n, 2)) |-> $past(start && !busy, 2))
        else $error("result without a command");

    // Back-to-back results: energy total moves by exactly the reported change
    a_energy_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && $past(o_result_valid))
        |-> (o_total_energy_out ==
             t_energy'($past(o_total_energy_out) + t_energy'(o_energy_change))))
        else $error("energy total does not follow energy change");

    // Back-to-back results: magnetization moves by two on an accept, else holds with zero energy change
    a_magnet_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && $past(o_result_valid))
        |-> (o_accepted
             ? ((t_magnet'(o_magnetization_out - $past(o_magnetization_out)) == MAG_STEP) ||
                (t_magnet'(o_magnetization_out - $past(o_magnetization_out)) == -MAG_STEP))
             : ($stable(o_magnetization_out) && (o_energy_change == '0))))
        else $error("magnetization step inconsistent with accepted flag");

endmodule

bind ising_metropolis_spin_update ims_checker u_ims_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .start               (start),
    .busy                (busy),
    .o_result_valid      (o_result_valid),
    .o_accepted          (o_accepted),
    .o_energy_change     (o_energy_change),
    .o_total_energy_out  (o_total_energy_out),
    .o_magnetization_out (o_magnetization_out)
);

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
    import ims_pkg::*;

    localparam int  CLK_HALF   = 5;
    localparam int  CYCLE_CAP  = 400000;
    localparam int  SETTLE_CYC = 8;
    localparam int  CHUNK_LEN  = 200;
    localparam int  HOLD_EVERY = 97;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;
    localparam t_thr THR_NEVER  = 17'd0;
    localparam t_thr THR_ONE    = 17'd1;
    localparam t_thr THR_RND_MAX = 17'd65535;
    localparam t_thr THR_ALWAYS = 17'd65536;
    localparam t_thr THR_FULL   = 17'h1FFFF;

    // One command to the lattice
    typedef struct packed {
        t_cmd cmd;
        t_row row;
        t_col col;
        logic spin;
        t_rnd rnd;
    } t_site_cmd;

    // One update result
    typedef struct packed {
        logic    accepted;
        t_de     energy_change;
        t_energy energy;
        t_magnet magnet;
    } t_site_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    t_thr                  i_cfg_data;
    logic                  o_result_valid;
    logic                  o_accepted;
    t_de                   o_energy_change;
    t_energy               o_total_energy_out;
    t_magnet               o_magnetization_out;

    t_site_cmd             drv_cmd;
    t_site_cmd             cmd_queue[$];
    t_site_result          site_result_q[$];

    // Predictor state
    logic                  lattice[SIDE][SIDE];
    t_energy               energy_acc;
    t_magnet               magnet_acc;
    t_thr                  thr_low;
    t_thr                  thr_high;

    int                    gap_pct;
    int                    queued_cnt;
    int                    taken_cnt;
    int                    issued_cnt;
    int                    mismatch_cnt;
    int                    cycle_cnt;
    logic                  took_cmd;
    logic                  drain_hold;

    ising_metropolis_spin_update dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_command           (drv_cmd.cmd),
        .i_row               (drv_cmd.row),
        .i_column            (drv_cmd.col),
        .i_spin_value        (drv_cmd.spin),
        .i_random_fraction   (drv_cmd.rnd),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_result_valid      (o_result_valid),
        .o_accepted          (o_accepted),
        .o_energy_change     (o_energy_change),
        .o_total_energy_out  (o_total_energy_out),
        .o_magnetization_out (o_magnetization_out)
    );

    // Clock
    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic int spin_of(input int r, input int c);
        return lattice[r][c] ? 1 : -1;
    endfunction

    // Metropolis update on the local lattice copy; returns the expected result
    function automatic t_site_result metropolis_predict(input t_site_cmd sc);
        t_site_result res;
        int           r, c, up, dn, lf, rt;
        int           old_s, nsum, de;
        logic         flip;
        r     = int'(sc.row) % SIDE;
        c     = int'(sc.col) % SIDE;
        up    = (r + SIDE - 1) % SIDE;
        dn    = (r + 1) % SIDE;
        lf    = (c + SIDE - 1) % SIDE;
        rt    = (c + 1) % SIDE;
        old_s = spin_of(r, c);
        nsum  = spin_of(up, c) + spin_of(dn, c) + spin_of(r, lf) + spin_of(r, rt);
        de    = 2 * old_s * nsum;
        if (sc.cmd == CMD_LOAD)
            flip = (sc.spin != lattice[r][c]);
        else if (de <= 0)
            flip = 1'b1;
        else if (de == 4)
            flip = ({1'b0, sc.rnd} < thr_low);
        else
            flip = ({1'b0, sc.rnd} < thr_high);
        if (flip) begin
            lattice[r][c] = ~lattice[r][c];
            energy_acc    = energy_acc + t_energy'(de);
            magnet_acc    = magnet_acc - t_magnet'(2 * old_s);
        end else begin
            de = 0;
        end
        res.accepted      = flip;
        res.energy_change = t_de'(de);
        res.energy        = energy_acc;
        res.magnet        = magnet_acc;
        return res;
    endfunction

    // Monitor: check results, predict on each command transfer, track config
    always @(posedge i_clk) begin : monitor
        t_site_result want;
        if (o_result_valid) begin
            if (site_result_q.size() == 0) begin
                report_mismatch("result with no command outstanding");
            end else begin
                want = site_result_q.pop_front();
                if (o_accepted !== want.accepted)
                    report_mismatch($sformatf("accepted %0b, expected %0b",
                                              o_accepted, want.accepted));
                if (o_energy_change !== want.energy_change)
                    report_mismatch($sformatf("energy_change %0d, expected %0d",
                                              o_energy_change, want.energy_change));
                if (o_total_energy_out !== want.energy)
                    report_mismatch($sformatf("total energy %0d, expected %0d",
                                              o_total_energy_out, want.energy));
                if (o_magnetization_out !== want.magnet)
                    report_mismatch($sformatf("magnetization %0d, expected %0d",
                                              o_magnetization_out, want.magnet));
            end
        end
        if (i_rst_n && start && !busy) begin
            site_result_q.push_back(metropolis_predict(drv_cmd));
            taken_cnt++;
        end
        took_cmd <= i_rst_n && start && !busy;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_THR_LOW:  thr_low  = i_cfg_data;
                CFG_THR_HIGH: thr_high = i_cfg_data;
                default: ;
            endcase
        end
    end

    // Driver: next command after each transfer, random gaps, periodic drain hold
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took_cmd) begin
            if (drain_hold) begin
                start <= 1'b0;
                if (site_result_q.size() == 0)
                    drain_hold <= 1'b0;
            end else if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
                start   <= 1'b1;
                drv_cmd <= cmd_queue.pop_front();
                issued_cnt++;
                if (issued_cnt % HOLD_EVERY == 0)
                    drain_hold <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic add_cmd(input t_cmd cmd, input int row, input int col,
                           input logic spin, input int rnd);
        t_site_cmd sc;
        sc.cmd  = cmd;
        sc.row  = t_row'(row);
        sc.col  = t_col'(col);
        sc.spin = spin;
        sc.rnd  = t_rnd'(rnd);
        cmd_queue.push_back(sc);
        queued_cnt++;
    endtask

    // Wait until every queued command is taken and every result is in
    task automatic wait_idle();
        while (taken_cnt != queued_cnt || site_result_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input t_thr data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_thresholds(input t_thr low, input t_thr high);
        wait_idle();
        write_cfg(CFG_THR_LOW, low);
        write_cfg(CFG_THR_HIGH, high);
        @(posedge i_clk);
    endtask

    function automatic t_thr pick_threshold();
        case ($urandom_range(0, 5))
            0:       return THR_NEVER;
            1:       return THR_ONE;
            2:       return THR_RND_MAX;
            3:       return THR_ALWAYS;
            4:       return THR_FULL;
            default: return t_thr'($urandom_range(0, 131071));
        endcase
    endfunction

    // Random command; many land in a small patch across the wrap corner
    task automatic add_random_cmd();
        int   row, col, rnd;
        t_cmd cmd;
        if ($urandom_range(0, 99) < 40) begin
            row = $urandom_range(0, 3) + SIDE - 2;
            col = $urandom_range(0, 3) + SIDE - 2;
        end else begin
            row = $urandom_range(0, SIDE - 1);
            col = $urandom_range(0, SIDE - 1);
        end
        cmd = ($urandom_range(0, 99) < 30) ? CMD_LOAD : CMD_STEP;
        case ($urandom_range(0, 9))
            0:       rnd = int'(thr_low) - $urandom_range(0, 1);
            1:       rnd = int'(thr_high) - $urandom_range(0, 1);
            default: rnd = $urandom_range(0, 65535);
        endcase
        add_cmd(cmd, row, col, $urandom_range(0, 1), rnd);
    endtask

    initial begin
        int phase_gap[3];
        phase_gap = '{38, 83, 0};
        i_rst_n      = 1'b0;
        start        = 1'b0;
        drv_cmd      = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        took_cmd     = 1'b0;
        drain_hold   = 1'b0;
        gap_pct      = 38;
        queued_cnt   = 0;
        taken_cnt    = 0;
        issued_cnt   = 0;
        mismatch_cnt = 0;
        cycle_cnt    = 0;
        energy_acc   = EN_RESET;
        magnet_acc   = MAG_RESET;
        thr_low      = '0;
        thr_high     = '0;
        foreach (lattice[r, c]) lattice[r][c] = 1'b1;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Unused register indexes: writes must be ignored
        write_cfg(CFG_IDX_SPARE_A, THR_FULL);
        write_cfg(CFG_IDX_SPARE_B, THR_ALWAYS);
        @(posedge i_clk);

        // Reset thresholds: only steps with a non-positive energy change flip
        add_cmd(CMD_STEP, 0, 0, 1'b1, 0);             // rise of eight, rejected
        add_cmd(CMD_LOAD, 63, 63, 1'b1, 0);           // load of unchanged spin
        add_cmd(CMD_LOAD, 0, 0, 1'b0, 65535);         // load that flips
        add_cmd(CMD_STEP, 0, 1, 1'b0, 0);             // rise of four, rejected
        add_cmd(CMD_STEP, 0, 0, 1'b1, 65535);         // drop of eight, flips back
        add_cmd(CMD_LOAD, 0, 63, 1'b0, 0);
        add_cmd(CMD_LOAD, 63, 0, 1'b0, 0);
        add_cmd(CMD_STEP, 0, 0, 1'b0, 65535);         // zero change always flips
        add_cmd(CMD_STEP, 0, 0, 1'b1, 0);
        add_cmd(CMD_LOAD, 63, 63, 1'b0, 65535);

        // Thresholds high enough that every rise is accepted
        set_thresholds(THR_ALWAYS, THR_FULL);
        add_cmd(CMD_STEP, 32, 32, 1'b1, 65535);
        add_cmd(CMD_STEP, 32, 33, 1'b0, 65535);
        add_cmd(CMD_STEP, 31, 31, 1'b1, 0);
        add_cmd(CMD_LOAD, 32, 32, 1'b1, 0);

        // Thresholds at the comparison boundaries
        set_thresholds(THR_ONE, THR_RND_MAX);
        add_cmd(CMD_STEP, 10, 10, 1'b1, 65535);       // not below, rejected
        add_cmd(CMD_STEP, 10, 10, 1'b0, 65534);       // just below, flips
        add_cmd(CMD_STEP, 10, 11, 1'b1, 1);           // rise of four, rejected
        add_cmd(CMD_STEP, 10, 11, 1'b0, 0);           // rise of four, flips
        add_cmd(CMD_STEP, 63, 0, 1'b1, 0);

        // Random part: three gap settings, fresh thresholds per chunk
        for (int p = 0; p < 3; p++) begin
            for (int k = 0; k < 3; k++) begin
                wait_idle();
                gap_pct = phase_gap[p];
                if ($urandom_range(0, 3) == 0)
                    write_cfg($urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                              t_thr'($urandom_range(0, 131071)));
                set_thresholds(pick_threshold(), pick_threshold());
                for (int n = 0; n < CHUNK_LEN; n++)
                    add_random_cmd();
            end
        end

        wait_idle();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
